>>> hw/rtl/uef_pkg.sv
// ----------------------------------------------------------------------------
// uef_pkg: shared types and decode functions of the UTF-8 emoji filter
// Word structs for both channels, the result bundle handed from the decoder
// to the serialiser, and the sequence decode helpers.
// ----------------------------------------------------------------------------
package uef_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CpWidth    = 21;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } uef_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } uef_out_t;

  // Up to four result words produced by one input word.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] word;
    logic [2:0]                 cnt;
    logic                       byte_valid;
    logic                       last;
  } uef_bundle_t;

  // Sequence length from the lead byte, 0 for a stray lead.
  function automatic logic [2:0] uef_seq_len(input logic [7:0] c);
    logic [2:0] l;
    if (c[7] == 1'b0) begin
      l = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      l = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      l = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      l = 3'd4;
    end else begin
      l = 3'd0;
    end
    return l;
  endfunction

  // Tail bytes contribute their low six bits, unchecked.
  function automatic logic [CpWidth-1:0] uef_code_point(input logic [3:0][7:0] b,
                                                         input logic [2:0] l);
    logic [CpWidth-1:0] cp;
    case (l)
      3'd2:    cp = CpWidth'({b[0][4:0], b[1][5:0]});
      3'd3:    cp = CpWidth'({b[0][3:0], b[1][5:0], b[2][5:0]});
      3'd4:    cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      default: cp = CpWidth'(b[0]);
    endcase
    return cp;
  endfunction

  function automatic logic uef_is_emoji(input logic [CpWidth-1:0] cp);
    return (cp >= 21'h1F000 && cp <= 21'h1FFFF) ||
           (cp >= 21'h02600 && cp <= 21'h027BF) ||
           (cp >= 21'h02300 && cp <= 21'h023FF) ||
           (cp >= 21'h02B00 && cp <= 21'h02BFF) ||
           (cp >= 21'h0FE00 && cp <= 21'h0FE0F) ||
           (cp == 21'h0200D);
  endfunction

  // Parse up to four bytes: drop stray leads and leads whose sequence does
  // not fit, drop emoji sequences whole, pass the rest byte for byte.
  function automatic uef_bundle_t uef_parse(input logic [3:0][7:0] b,
                                            input logic [2:0] len);
    uef_bundle_t      res;
    logic [2:0]       pos;
    logic [2:0]       l;
    logic [2:0]       n;
    logic [3:0][7:0]  seq;
    res = '0;
    pos = 3'd0;
    n   = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) == pos && 3'(i) < len) begin
        l = uef_seq_len(b[i]);
        if (l == 3'd0 || 3'(i) + l > len) begin
          pos = pos + 3'd1;
        end else begin
          seq = b >> (8 * i);
          if (!uef_is_emoji(uef_code_point(seq, l))) begin
            for (int k = 0; k < 4; k++) begin
              if (3'(k) < l) begin
                res.word[n[1:0]] = seq[k];
                n = n + 3'd1;
              end
            end
          end
          pos = pos + l;
        end
      end
    end
    res.cnt = n;
    return res;
  endfunction

endpackage

>>> hw/rtl/uef_decode.sv
// ----------------------------------------------------------------------------
// uef_decode: sequence state and single-pass decode
// Holds the open sequence and turns each accepted word that completes a sequence or ends a text into a result bundle.
// ----------------------------------------------------------------------------
module uef_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  uef_pkg::uef_in_t     in_data,
  output logic                 bundle_load,
  output uef_pkg::uef_bundle_t bundle
);

  logic [7:0] held_r [3];
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] need_r, need_nxt;

  logic                 held_we;
  logic [1:0]           pos;
  logic [2:0]           len;
  logic [2:0]           lead_len;
  logic                 emit;
  logic [3:0][7:0]      buf_b;
  uef_pkg::uef_bundle_t parsed;

  // Held bytes followed by the new byte.
  always_comb begin
    pos   = (need_r != 3'd0) ? cnt_r : 2'd0;
    len   = {1'b0, pos} + 3'd1;
    buf_b = {8'h00, held_r[2], held_r[1], held_r[0]};
    buf_b[pos] = in_data.in_byte;
  end

  assign parsed   = uef_pkg::uef_parse(buf_b, len);
  assign lead_len = uef_pkg::uef_seq_len(in_data.in_byte);

  always_comb begin
    cnt_nxt  = cnt_r;
    need_nxt = need_r;
    held_we  = 1'b0;
    emit     = 1'b0;
    bundle   = parsed;
    bundle.byte_valid = 1'b1;
    bundle.last       = 1'b0;
    if (in_data.in_last) begin
      emit        = 1'b1;
      bundle.last = 1'b1;
      if (parsed.cnt == 3'd0) begin
        bundle.word       = '0;
        bundle.cnt        = 3'd1;
        bundle.byte_valid = 1'b0;
      end
      cnt_nxt  = 2'd0;
      need_nxt = 3'd0;
    end else if (need_r == 3'd0) begin
      if (lead_len == 3'd1) begin
        emit = 1'b1;
      end else if (lead_len != 3'd0) begin
        held_we  = 1'b1;
        cnt_nxt  = 2'd1;
        need_nxt = lead_len;
      end
    end else if ({1'b0, cnt_r} + 3'd1 >= need_r) begin
      emit     = 1'b1;
      cnt_nxt  = 2'd0;
      need_nxt = 3'd0;
    end else begin
      held_we = 1'b1;
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  assign bundle_load = accept && emit && (bundle.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      need_r <= 3'd0;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      need_r <= need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held_r[pos] <= in_data.in_byte;
    end
  end

endmodule

>>> hw/rtl/uef_serial.sv
// ----------------------------------------------------------------------------
// uef_serial: result register and word serialiser
// Holds one result bundle and hands its words out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module uef_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 bundle_load,
  input  uef_pkg::uef_bundle_t bundle,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_stall,
  output uef_pkg::uef_out_t    out_data
);

  logic                 valid_r;
  logic [1:0]           idx_r;
  uef_pkg::uef_bundle_t bundle_r;
  logic                 at_end;
  logic                 finishing;

  assign at_end    = ({1'b0, idx_r} + 3'd1) == bundle_r.cnt;
  assign finishing = valid_r && !out_stall && at_end;
  assign can_load  = !valid_r || finishing;

  assign out_valid           = valid_r;
  assign out_data.out_byte   = bundle_r.word[idx_r];
  assign out_data.byte_valid = bundle_r.byte_valid;
  assign out_data.out_last   = bundle_r.last && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (bundle_load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (finishing) begin
      valid_r <= 1'b0;
    end else if (valid_r && !out_stall) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_load) begin
      bundle_r <= bundle;
    end
  end

endmodule

>>> hw/rtl/utf8_emoji_filter.sv
// ----------------------------------------------------------------------------
// utf8_emoji_filter: streaming UTF-8 emoji filter
// Removes emoji code points and the zero-width joiner from a byte stream; stray lead bytes are dropped too.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one text byte per word,
//   with in_last set on the final byte of a text. Output channel
//   (out_valid/out_stall/out_data) gives the filtered text one byte per word;
//   out_last marks the final word of a text, and if the text ends with
//   nothing left to pass, a single word with byte_valid clear carries it.
//   The first result word of an input word appears on the output in the
//   cycle after acceptance. Throughput: one input word per cycle while
//   each yields at most one result word and out_stall stays low; a word
//   completing a passed multi-byte sequence holds the result register until
//   its last byte is taken, keeping in_stall high meanwhile.
//   A new word is accepted in the same cycle the last word of the pending
//   result is taken. When the receiver stalls, the result word holds and
//   the input stalls once the result register is full.
//   Reset clears the open sequence and empties the result register.
// ----------------------------------------------------------------------------
module utf8_emoji_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  uef_pkg::uef_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output uef_pkg::uef_out_t out_data
);

  logic                 accept;
  logic                 can_load;
  logic                 bundle_load;
  uef_pkg::uef_bundle_t bundle;

  // Take a word only when the result register frees up this cycle.
  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  // Decode against the open sequence and form the result bundle.
  uef_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_data     (in_data),
    .bundle_load (bundle_load),
    .bundle      (bundle)
  );

  // Hold the bundle and advance through its words.
  uef_serial u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .bundle_load (bundle_load),
    .bundle      (bundle),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

>>> verif/utf8_emoji_filter_test.sv
// ----------------------------------------------------------------------------
// utf8_emoji_filter_test: self-checking bench for the UTF-8 emoji filter
// Feeds directed and random UTF-8 texts one byte per word, predicts the
// filtered text in a scoreboard and checks every output word against it,
// with random gaps and stalls on both channels and one long output hold.
// ----------------------------------------------------------------------------
module utf8_emoji_filter_test;

  localparam int unsigned RandomWords = 500;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePercent = 36;
  localparam int unsigned HoldAt      = 60;    // input words sent before the long hold
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned CalmFrom    = 250;   // stretch with no gaps and no stalls
  localparam int unsigned CalmTo      = 370;
  localparam int unsigned DrainCycles = 16;

  // Code points on and around the edges of the filtered BMP ranges.
  localparam logic [15:0] EdgeCp [19] = '{
    16'h22FF, 16'h2300, 16'h23FF, 16'h2400, 16'h25FF, 16'h2600, 16'h27BF,
    16'h27C0, 16'h2AFF, 16'h2B00, 16'h2BFF, 16'h2C00, 16'h200C, 16'h200D,
    16'h200E, 16'hFDFF, 16'hFE00, 16'hFE0F, 16'hFE10
  };

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the open sequence and builds the
  // filtered text that the block should produce, word by word.
  // --------------------------------------------------------------------------
  class filter_scoreboard;
    uef_pkg::uef_out_t expected_text[$];
    logic [7:0]        open_seq[3];
    int unsigned       open_count;
    int unsigned       open_len;
    int unsigned       mismatches;
    int unsigned       words_in;
    int unsigned       words_out;
    int unsigned       texts_done;
    int unsigned       dropped_seqs;

    function new();
      clear_seq();
      mismatches   = 0;
      words_in     = 0;
      words_out    = 0;
      texts_done   = 0;
      dropped_seqs = 0;
    endfunction

    function void clear_seq();
      open_seq   = '{default: 8'h00};
      open_count = 0;
      open_len   = 0;
    endfunction

    // Length of the sequence a lead byte opens; 0 for a stray lead.
    function int unsigned lead_len(logic [7:0] c);
      casez (c)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        default:     return 0;
      endcase
    endfunction

    // Tail bytes give their low six bits whatever their top bits are.
    function logic [20:0] decode(logic [3:0][7:0] s, int unsigned n);
      logic [20:0] cp;
      case (n)
        1:       cp = 21'(s[0]);
        2:       cp = 21'(s[0][4:0]);
        3:       cp = 21'(s[0][3:0]);
        default: cp = 21'(s[0][2:0]);
      endcase
      for (int k = 1; k < n; k++) cp = (cp << 6) | 21'(s[k][5:0]);
      return cp;
    endfunction

    function bit is_filtered(logic [20:0] cp);
      return cp inside {[21'h1F000:21'h1FFFF], [21'h02600:21'h027BF],
                        [21'h02300:21'h023FF], [21'h02B00:21'h02BFF],
                        [21'h0FE00:21'h0FE0F], 21'h0200D};
    endfunction

    // Drop a filtered sequence whole, otherwise queue its bytes.
    function void pass_seq(logic [3:0][7:0] s, int unsigned n);
      uef_pkg::uef_out_t w;
      if (is_filtered(decode(s, n))) begin
        dropped_seqs++;
        return;
      end
      for (int k = 0; k < n; k++) begin
        w            = '0;
        w.out_byte   = s[k];
        w.byte_valid = 1'b1;
        expected_text.push_back(w);
      end
    endfunction

    function void note_input(uef_pkg::uef_in_t w);
      logic [3:0][7:0]   line;
      logic [3:0][7:0]   seq;
      uef_pkg::uef_out_t marker;
      int unsigned       len;
      int unsigned       pos;
      int unsigned       l;
      int unsigned       start;
      words_in++;
      seq = '0;
      if (w.in_last) begin
        // End of text: parse the held bytes again with the end known.
        line = '0;
        len  = 0;
        if (open_len != 0) begin
          for (int k = 0; k < open_count; k++) begin
            line[len] = open_seq[k];
            len++;
          end
        end
        line[len] = w.in_byte;
        len++;
        start = expected_text.size();
        pos   = 0;
        while (pos < len) begin
          l = lead_len(line[pos]);
          if (l == 0 || pos + l > len) begin
            pos++;
          end else begin
            seq = line >> (8 * pos);
            pass_seq(seq, l);
            pos += l;
          end
        end
        // Mark the final word; a bare marker if the text ended with nothing.
        if (expected_text.size() == start) begin
          marker = '0;
        end else begin
          marker = expected_text[expected_text.size() - 1];
          expected_text.delete(expected_text.size() - 1);
        end
        marker.out_last = 1'b1;
        expected_text.push_back(marker);
        texts_done++;
        clear_seq();
      end else if (open_len == 0) begin
        l = lead_len(w.in_byte);
        if (l == 1) begin
          seq[0] = w.in_byte;
          pass_seq(seq, 1);
        end else if (l != 0) begin
          open_seq[0] = w.in_byte;
          open_count  = 1;
          open_len    = l;
        end
      end else if (open_count + 1 >= open_len) begin
        for (int k = 0; k < open_count; k++) seq[k] = open_seq[k];
        seq[open_len - 1] = w.in_byte;
        pass_seq(seq, open_len);
        clear_seq();
      end else begin
        open_seq[open_count] = w.in_byte;
        open_count++;
      end
    endfunction

    function void check_output(uef_pkg::uef_out_t got);
      uef_pkg::uef_out_t want;
      words_out++;
      if (expected_text.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output word: byte=%02h byte_valid=%0b last=%0b",
                 $time, got.out_byte, got.byte_valid, got.out_last);
        return;
      end
      want = expected_text.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.out_last !== want.out_last) begin
        mismatches++;
        $display("%0t: output mismatch: expected byte=%02h byte_valid=%0b last=%0b, %s",
                 $time, want.out_byte, want.byte_valid, want.out_last, "got");
        $display("%0t:   actual byte=%02h byte_valid=%0b last=%0b",
                 $time, got.out_byte, got.byte_valid, got.out_last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  uef_pkg::uef_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  uef_pkg::uef_out_t out_data;

  always #4 clk = ~clk;

  utf8_emoji_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  filter_scoreboard sb;
  uef_pkg::uef_in_t stim[$];
  logic [7:0]       text_q[$];
  int unsigned      sent_count;
  int unsigned      cycle_count = 0;
  bit               hold_done   = 1'b0;

  // No gaps and no stalls on either side while this holds.
  function automatic bit calm();
    return sent_count >= CalmFrom && sent_count < CalmTo;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: texts are gathered byte by byte, then flushed as input words
  // with the last flag on the final byte.
  // --------------------------------------------------------------------------
  function automatic void close_text();
    uef_pkg::uef_in_t w;
    foreach (text_q[k]) begin
      w.in_byte = text_q[k];
      w.in_last = (k == text_q.size() - 1);
      stim.push_back(w);
    end
    text_q.delete();
  endfunction

  // Encode a code point in n bytes (overlong where the code point is small),
  // keep only the first bytes if asked, and optionally corrupt one tail byte.
  function automatic void add_code_point(logic [20:0] cp, int unsigned n,
                                         int unsigned keep, bit loose);
    logic [3:0][7:0] enc;
    enc = '0;
    case (n)
      1:       enc[0] = {1'b0, cp[6:0]};
      2:       enc[0] = {3'b110, cp[10:6]};
      3:       enc[0] = {4'b1110, cp[15:12]};
      default: enc[0] = {5'b11110, cp[20:18]};
    endcase
    for (int k = 1; k < n; k++) enc[k] = {2'b10, cp[6 * (n - 1 - k) +: 6]};
    if (loose && n > 1) enc[$urandom_range(n - 1, 1)] = 8'($urandom_range(255, 0));
    for (int k = 0; k < keep; k++) text_q.push_back(enc[k]);
  endfunction

  function automatic void add_random_unit(bit truncate);
    int unsigned pick;
    int unsigned n;
    int unsigned keep;
    logic [20:0] cp;
    bit          loose;
    pick  = $urandom_range(99, 0);
    loose = 1'b0;
    if (pick < 5) begin
      // stray lead: a continuation byte or an invalid high byte
      text_q.push_back($urandom_range(1, 0) ? 8'($urandom_range(8'hBF, 8'h80))
                                            : 8'($urandom_range(8'hFF, 8'hF8)));
      return;
    end
    if (pick < 10) begin
      text_q.push_back(8'($urandom_range(255, 0)));
      return;
    end
    if (pick < 35) begin
      n  = 1;
      cp = 21'($urandom_range(8'h7F, 0));
    end else if (pick < 47) begin
      n  = 2;
      cp = 21'($urandom_range(11'h7FF, 0));
    end else if (pick < 72) begin
      n  = 3;
      cp = $urandom_range(1, 0) ? 21'(EdgeCp[$urandom_range(18, 0)])
                                : 21'($urandom_range(16'hFFFF, 0));
    end else if (pick < 90) begin
      n = 4;
      case ($urandom_range(3, 0))
        0, 1:    cp = 21'h1F000 + 21'($urandom_range(12'hFFF, 0));
        2: begin
          case ($urandom_range(3, 0))
            0:       cp = 21'h1EFFF;
            1:       cp = 21'h1F000;
            2:       cp = 21'h1FFFF;
            default: cp = 21'h20000;
          endcase
        end
        default: cp = 21'($urandom);
      endcase
    end else begin
      n     = $urandom_range(4, 2);
      cp    = 21'($urandom);
      loose = 1'b1;
    end
    keep = n;
    if (truncate && n > 1) keep = $urandom_range(n - 1, 1);
    add_code_point(cp, n, keep, loose);
  endfunction

  function automatic void build_directed();
    // plain text, passed sequences, filtered sequences, stray and
    // unchecked bytes, with an overlong NUL completing on the last byte
    text_q = '{8'h00, 8'hC3, 8'hA9, 8'hE2, 8'h80, 8'h8D, 8'hE2, 8'h98, 8'h80,
               8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hFF,
               8'hC3, 8'h41, 8'hC0, 8'h80};
    close_text();
    // text ending inside a four-byte sequence: lead dropped, rest re-parsed
    text_q = '{8'hF0, 8'h9F, 8'h41};
    close_text();
    // text that ends with nothing to pass: bare end marker
    text_q = '{8'hFF};
    close_text();
  endfunction

  function automatic void build_random();
    int unsigned target;
    int unsigned units;
    target = stim.size() + RandomWords;
    while (stim.size() < target) begin
      units = $urandom_range(8, 1);
      for (int u = 0; u < units; u++) begin
        add_random_unit(u == units - 1 && $urandom_range(3, 0) == 0);
      end
      close_text();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side: change on the falling edge, hold the word until accepted.
  // --------------------------------------------------------------------------
  task automatic send_word(input uef_pkg::uef_in_t w);
    while (!calm() && $urandom_range(99, 0) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sent_count++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls, plus one long hold so the block backs up
  // into its input while the sender keeps offering words.
  // --------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= HoldAt) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        out_stall <= !calm() && ($urandom_range(99, 0) < IdlePercent);
      end
    end
  end

  // Sample both handshakes on the rising edge and feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_output(out_data);
    end
  end

  // Watchdog: end the run if the output never drains.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d output words outstanding",
               $time, sb.expected_text.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb         = new();
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    sent_count = 0;
    build_directed();
    build_random();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim[k]) send_word(stim[k]);
    in_valid <= 1'b0;

    // Drain: wait for every predicted word, then watch for strays.
    while (sb.expected_text.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d bytes in %0d texts; checked %0d filtered words.",
             sb.words_in, sb.texts_done, sb.words_out);
    $display("%0d sequences fell in the emoji or joiner ranges and were removed.",
             sb.dropped_seqs);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/uef_pkg.sv
hw/rtl/uef_decode.sv
hw/rtl/uef_serial.sv
hw/rtl/utf8_emoji_filter.sv
verif/utf8_emoji_filter_test.sv
